// File: sv/pad_event_to_action_repeat_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the pad event to action block
// Short forms for clocked, reset-gated assertion properties.
// ----------------------------------------------------------------------------
`ifndef PAD_EVENT_TO_ACTION_REPEAT_MACROS_SVH
`define PAD_EVENT_TO_ACTION_REPEAT_MACROS_SVH

// Same-cycle implication.
`define PEAR_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PEAR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/pear_pkg.sv
// ----------------------------------------------------------------------------
// pear_pkg
// Shared types and codes of the pad event to action mapper.
// ----------------------------------------------------------------------------
package pear_pkg;

  typedef enum logic [1:0] {
    OP_KEY    = 2'd0,
    OP_AXIS   = 2'd1,
    OP_TICK   = 2'd2,
    OP_ATTACH = 2'd3
  } opcode_t;

  // Menu actions; the four directions share codes with the action field.
  localparam logic [1:0] DIR_UP    = 2'd0;
  localparam logic [1:0] DIR_DOWN  = 2'd1;
  localparam logic [1:0] DIR_LEFT  = 2'd2;
  localparam logic [1:0] DIR_RIGHT = 2'd3;

  localparam logic [3:0] ACT_CONFIRM  = 4'd4;
  localparam logic [3:0] ACT_BACK     = 4'd5;
  localparam logic [3:0] ACT_FAVORITE = 4'd6;
  localparam logic [3:0] ACT_VIEW     = 4'd7;
  localparam logic [3:0] ACT_TABPREV  = 4'd8;
  localparam logic [3:0] ACT_TABNEXT  = 4'd9;
  localparam logic [3:0] ACT_JUMPPREV = 4'd10;
  localparam logic [3:0] ACT_JUMPNEXT = 4'd11;
  localparam logic [3:0] ACT_QUIT     = 4'd12;

  // Configuration register indexes (word address).
  localparam int          ADDR_W         = 4;
  localparam logic [1:0]  REG_DELAY      = 2'd0;
  localparam logic [1:0]  REG_INTERVAL   = 2'd1;
  localparam logic [1:0]  REG_THRESHOLD  = 2'd2;

  localparam logic [15:0] DELAY_RESET     = 16'd380;
  localparam logic [15:0] INTERVAL_RESET  = 16'd85;
  localparam logic [30:0] THRESHOLD_RESET = 31'd16000;

  // Request to change the held direction.
  typedef struct packed {
    logic       press;
    logic [1:0] press_dir;
    logic       rel;
    logic [1:0] rel_dir;
  } hold_req_t;

  typedef struct packed {
    logic       valid;
    logic [3:0] action;
  } result_t;

endpackage

// File: sv/pear_key_map.sv
// ----------------------------------------------------------------------------
// pear_key_map
// Maps key codes to direction presses/releases and menu actions.
// ----------------------------------------------------------------------------
module pear_key_map (
  input  logic                  en,
  input  logic [9:0]            code,
  input  logic                  pressed,
  output pear_pkg::hold_req_t   hreq,
  output pear_pkg::result_t     res
);
  import pear_pkg::*;

  logic       is_dir;
  logic [1:0] dir;
  logic       is_act;
  logic [3:0] act;

  always_comb begin
    is_dir = 1'b0;
    dir    = DIR_UP;
    unique case (code) inside
      10'd103, 10'd544: begin is_dir = 1'b1; dir = DIR_UP;    end
      10'd108, 10'd545: begin is_dir = 1'b1; dir = DIR_DOWN;  end
      10'd105, 10'd546: begin is_dir = 1'b1; dir = DIR_LEFT;  end
      10'd106, 10'd547: begin is_dir = 1'b1; dir = DIR_RIGHT; end
      default: begin is_dir = 1'b0; dir = DIR_UP; end
    endcase
  end

  always_comb begin
    is_act = 1'b1;
    act    = ACT_CONFIRM;
    unique case (code) inside
      10'd304, 10'd315, 10'd28, 10'd96, 10'd57: act = ACT_CONFIRM;
      10'd305, 10'd1, 10'd14:                   act = ACT_BACK;
      10'd308, 10'd33:                          act = ACT_FAVORITE;
      10'd307, 10'd47:                          act = ACT_VIEW;
      10'd310, 10'd104:                         act = ACT_TABPREV;
      10'd311, 10'd109, 10'd15:                 act = ACT_TABNEXT;
      10'd312, 10'd51:                          act = ACT_JUMPPREV;
      10'd313, 10'd52:                          act = ACT_JUMPNEXT;
      10'd16:                                   act = ACT_QUIT;
      default: is_act = 1'b0;
    endcase
  end

  always_comb begin
    hreq.press     = en && is_dir && pressed;
    hreq.press_dir = dir;
    hreq.rel       = en && is_dir && !pressed;
    hreq.rel_dir   = dir;
    res.valid      = en && pressed && (is_dir || is_act);
    res.action     = is_dir ? {2'b00, dir} : act;
  end

endmodule

// File: sv/pear_axis_unit.sv
// ----------------------------------------------------------------------------
// pear_axis_unit
// Per-slot hat, stick and trigger state; turns axis events into actions.
// ----------------------------------------------------------------------------
module pear_axis_unit #(
  parameter int PAD_SLOTS = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en_axis,
  input  logic                  en_attach,
  input  logic [1:0]            slot,
  input  logic [9:0]            code,
  input  logic signed [31:0]    value,
  input  logic [30:0]           second_level,
  input  logic [30:0]           stick_threshold,
  output pear_pkg::hold_req_t   hreq,
  output pear_pkg::result_t     res
);
  import pear_pkg::*;

  localparam int         AXES   = 4;
  localparam logic [1:0] CENTRE = 2'b00;
  localparam logic [1:0] PLUS   = 2'b01;
  localparam logic [1:0] MINUS  = 2'b11;

  logic [AXES-1:0][1:0] pos    [PAD_SLOTS];
  logic [1:0]           pulled [PAD_SLOTS];
  logic [30:0]          lvl_l  [PAD_SLOTS];
  logic [30:0]          lvl_r  [PAD_SLOTS];

  logic [PAD_SLOTS-1:0] hit;
  logic                 slot_ok;
  logic [AXES-1:0][1:0] cur_pos;
  logic [1:0]           cur_pulled;
  logic [30:0]          cur_l;
  logic [30:0]          cur_r;

  logic                 is_axis;
  logic                 is_trig;
  logic                 hat;
  logic [1:0]           ax;
  logic [1:0]           neg_dir;
  logic [1:0]           pos_dir;
  logic                 trig_sel;
  logic [3:0]           trig_act;

  logic signed [32:0]   v;
  logic signed [32:0]   thr;
  logic [1:0]           old_pos;
  logic [1:0]           next_pos;
  logic                 changed;
  logic [30:0]          lvl;
  logic                 trig_on;
  logic                 next_pull;
  logic                 axis_go;
  logic                 trig_fire;

  always_comb begin
    for (int s = 0; s < PAD_SLOTS; s++) begin
      hit[s] = (32'(slot) == s);
    end
  end

  assign slot_ok = |hit;

  always_comb begin
    cur_pos    = '0;
    cur_pulled = '0;
    cur_l      = '0;
    cur_r      = '0;
    for (int s = 0; s < PAD_SLOTS; s++) begin
      if (hit[s]) begin
        cur_pos    = pos[s];
        cur_pulled = pulled[s];
        cur_l      = lvl_l[s];
        cur_r      = lvl_r[s];
      end
    end
  end

  always_comb begin
    is_axis  = 1'b0;
    is_trig  = 1'b0;
    hat      = 1'b0;
    ax       = 2'd0;
    neg_dir  = DIR_LEFT;
    pos_dir  = DIR_RIGHT;
    trig_sel = 1'b0;
    trig_act = ACT_JUMPPREV;
    unique case (code)
      10'd16: begin is_axis = 1'b1; hat = 1'b1; ax = 2'd0; end
      10'd17: begin
        is_axis = 1'b1; hat = 1'b1; ax = 2'd1; neg_dir = DIR_UP; pos_dir = DIR_DOWN;
      end
      10'd0:  begin is_axis = 1'b1; ax = 2'd2; end
      10'd1:  begin
        is_axis = 1'b1; ax = 2'd3; neg_dir = DIR_UP; pos_dir = DIR_DOWN;
      end
      10'd2:  begin is_trig = 1'b1; end
      10'd5:  begin is_trig = 1'b1; trig_sel = 1'b1; trig_act = ACT_JUMPNEXT; end
      default: is_axis = 1'b0;
    endcase
  end

  // Axis cut to three levels against a symmetric threshold.
  assign v        = {value[31], value};
  assign thr      = hat ? 33'sd1 : $signed({2'b00, stick_threshold});
  assign old_pos  = cur_pos[ax];
  assign next_pos = (v <= -thr) ? MINUS : ((v >= thr) ? PLUS : CENTRE);
  assign changed  = (next_pos != old_pos);
  assign axis_go  = en_axis && slot_ok && is_axis && changed;

  // A zero level disables the trigger.
  assign lvl       = trig_sel ? cur_r : cur_l;
  assign trig_on   = (lvl != '0);
  assign next_pull = (v >= $signed({2'b00, lvl}));
  assign trig_fire = en_axis && slot_ok && is_trig && trig_on && next_pull
                     && !cur_pulled[trig_sel];

  always_comb begin
    hreq.rel       = axis_go && (old_pos != CENTRE);
    hreq.rel_dir   = (old_pos == MINUS) ? neg_dir : pos_dir;
    hreq.press     = axis_go && (next_pos != CENTRE);
    hreq.press_dir = (next_pos == MINUS) ? neg_dir : pos_dir;
    res.valid      = hreq.press || trig_fire;
    res.action     = hreq.press ? {2'b00, hreq.press_dir} : trig_act;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < PAD_SLOTS; s++) begin
        pos[s]    <= '0;
        pulled[s] <= '0;
        lvl_l[s]  <= '0;
        lvl_r[s]  <= '0;
      end
    end else begin
      for (int s = 0; s < PAD_SLOTS; s++) begin
        if (hit[s] && en_attach) begin
          pos[s]    <= '0;
          pulled[s] <= '0;
          lvl_l[s]  <= value[31] ? '0 : value[30:0];
          lvl_r[s]  <= second_level;
        end else if (hit[s] && en_axis) begin
          if (is_axis) begin
            pos[s][ax] <= next_pos;
          end
          if (is_trig && trig_on) begin
            pulled[s][trig_sel] <= next_pull;
          end
        end
      end
    end
  end

endmodule

// File: sv/pear_repeat_timer.sv
// ----------------------------------------------------------------------------
// pear_repeat_timer
// Held direction with saturating delay and interval counters.
// ----------------------------------------------------------------------------
`include "pad_event_to_action_repeat_macros.svh"

module pear_repeat_timer #(
  parameter int TIMER_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  tick,
  input  pear_pkg::hold_req_t   hreq,
  input  logic [15:0]           repeat_delay_ms,
  input  logic [15:0]           repeat_interval_ms,
  output pear_pkg::result_t     res
);
  import pear_pkg::*;

  localparam int CMP_W = (TIMER_BITS > 16) ? TIMER_BITS : 16;

  logic                  held_valid;
  logic [1:0]            held_dir;
  logic [TIMER_BITS-1:0] held_elapsed;
  logic [TIMER_BITS-1:0] repeat_elapsed;
  logic [TIMER_BITS-1:0] held_elapsed_next;
  logic [TIMER_BITS-1:0] repeat_elapsed_next;
  logic                  due;
  logic                  fire;

  // Counters stop at all ones.
  assign held_elapsed_next   = (&held_elapsed) ? held_elapsed : held_elapsed + 1'b1;
  assign repeat_elapsed_next = (&repeat_elapsed) ? repeat_elapsed : repeat_elapsed + 1'b1;

  assign due  = !(CMP_W'(held_elapsed_next) < CMP_W'(repeat_delay_ms))
                && !(CMP_W'(repeat_elapsed_next) < CMP_W'(repeat_interval_ms));
  assign fire = tick && held_valid && due;

  assign res.valid  = fire;
  assign res.action = {2'b00, held_dir};

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid     <= 1'b0;
      held_dir       <= DIR_UP;
      held_elapsed   <= '0;
      repeat_elapsed <= '0;
    end else if (hreq.press) begin
      held_valid     <= 1'b1;
      held_dir       <= hreq.press_dir;
      held_elapsed   <= '0;
      repeat_elapsed <= '0;
    end else begin
      if (hreq.rel && held_valid && (held_dir == hreq.rel_dir)) begin
        held_valid <= 1'b0;
      end
      if (tick && held_valid) begin
        held_elapsed   <= held_elapsed_next;
        repeat_elapsed <= due ? '0 : repeat_elapsed_next;
      end
    end
  end

  `PEAR_ASSERT_NOW(a_held_covers_repeat, clk, rst, 1'b1, held_elapsed >= repeat_elapsed, "repeat counter ran ahead of held counter")
  `PEAR_ASSERT_NEXT(a_repeat_restarts, clk, rst, fire, repeat_elapsed == '0, "repeat counter not restarted after repeat")
  `PEAR_ASSERT_NOW(a_no_repeat_idle, clk, rst, !held_valid, !res.valid, "repeat with no held direction")

endmodule

// File: sv/pad_event_to_action_repeat.sv
// ----------------------------------------------------------------------------
// pad_event_to_action_repeat
// Pad key/axis event to menu action mapper with typematic auto-repeat.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): one item per transfer carrying opcode,
// slot, event_code, event_value and second_level. Opcodes are key event,
// axis event, one millisecond tick and slot attach.
// Output channel (out_valid/out_ready): one action per transfer; an item
// gives at most one action, and items that give none are simply consumed.
// Path: an item taken at the input lands in the input register, is decoded
// against the slot, trigger and repeat state and loads the result register
// once that register is free or drains.
// Throughput: one item per cycle while out_ready is high; the input register
// and the result register sit between the two channels.
// When the receiver stalls, the pending action holds in the result register,
// one more item waits in the input register, then in_ready drops.
// Reset clears the held direction, counters, axis and trigger state, trigger
// levels and loads the register defaults; the block is ready at once.
// Registers (APB, word aligned): repeat delay, repeat interval, stick
// threshold; the user must write them only while the block is idle (unguarded).
// ----------------------------------------------------------------------------
`include "pad_event_to_action_repeat_macros.svh"

module pad_event_to_action_repeat #(
  parameter int PAD_SLOTS  = 4,
  parameter int TIMER_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  opcode,
  input  logic [1:0]                  slot,
  input  logic [9:0]                  event_code,
  input  logic signed [31:0]          event_value,
  input  logic [30:0]                 second_level,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [3:0]                  action,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pear_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import pear_pkg::*;

  logic [15:0]        repeat_delay_ms;
  logic [15:0]        repeat_interval_ms;
  logic [30:0]        stick_threshold;

  logic               s1_valid;
  opcode_t            s1_op;
  logic [1:0]         s1_slot;
  logic [9:0]         s1_code;
  logic signed [31:0] s1_value;
  logic [30:0]        s1_second;
  logic               s1_go;

  hold_req_t          key_hreq;
  hold_req_t          axis_hreq;
  hold_req_t          hreq;
  result_t            key_res;
  result_t            axis_res;
  result_t            rep_res;
  result_t            res;

  // Configuration port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      repeat_delay_ms    <= DELAY_RESET;
      repeat_interval_ms <= INTERVAL_RESET;
      stick_threshold    <= THRESHOLD_RESET;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[3:2])
        REG_DELAY:     repeat_delay_ms    <= pwdata[15:0];
        REG_INTERVAL:  repeat_interval_ms <= pwdata[15:0];
        REG_THRESHOLD: stick_threshold    <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_DELAY:     prdata = {16'h0000, repeat_delay_ms};
      REG_INTERVAL:  prdata = {16'h0000, repeat_interval_ms};
      REG_THRESHOLD: prdata = {1'b0, stick_threshold};
      default:       prdata = '0;
    endcase
  end

  // Input register; advance whenever the result register is free or drains.
  assign s1_go    = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_op     <= opcode_t'(opcode);
      s1_slot   <= slot;
      s1_code   <= event_code;
      s1_value  <= event_value;
      s1_second <= second_level;
    end
  end

  pear_key_map u_key_map (
    .en      (s1_go && (s1_op == OP_KEY)),
    .code    (s1_code),
    .pressed (s1_value != '0),
    .hreq    (key_hreq),
    .res     (key_res)
  );

  pear_axis_unit #(
    .PAD_SLOTS (PAD_SLOTS)
  ) u_axis_unit (
    .clk             (clk),
    .rst             (rst),
    .en_axis         (s1_go && (s1_op == OP_AXIS)),
    .en_attach       (s1_go && (s1_op == OP_ATTACH)),
    .slot            (s1_slot),
    .code            (s1_code),
    .value           (s1_value),
    .second_level    (s1_second),
    .stick_threshold (stick_threshold),
    .hreq            (axis_hreq),
    .res             (axis_res)
  );

  // Take the hold request from the unit that owns the item.
  assign hreq = (s1_op == OP_KEY) ? key_hreq : axis_hreq;

  pear_repeat_timer #(
    .TIMER_BITS (TIMER_BITS)
  ) u_repeat_timer (
    .clk                (clk),
    .rst                (rst),
    .tick               (s1_go && (s1_op == OP_TICK)),
    .hreq               (hreq),
    .repeat_delay_ms    (repeat_delay_ms),
    .repeat_interval_ms (repeat_interval_ms),
    .res                (rep_res)
  );

  // Pick the action of whichever source fired.
  always_comb begin
    if (key_res.valid) begin
      res = key_res;
    end else if (axis_res.valid) begin
      res = axis_res;
    end else begin
      res = rep_res;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go) begin
      out_valid <= res.valid;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && res.valid) begin
      action <= res.action;
    end
  end

  `PEAR_ASSERT_NOW(a_one_source, clk, rst, 1'b1, $onehot0({key_res.valid, axis_res.valid, rep_res.valid}), "more than one action source on one item")
  `PEAR_ASSERT_NOW(a_stall_has_item, clk, rst, !in_ready, s1_valid && out_valid && !out_ready, "input stalled without a waiting item")
  `PEAR_ASSERT_NEXT(a_result_loaded, clk, rst, s1_go && res.valid, out_valid, "action lost on its way to the result register")

endmodule

// File: tb/sv/tb_pad_event_to_action_repeat.sv
// ----------------------------------------------------------------------------
// tb_pad_event_to_action_repeat
// Self-checking bench for the pad event to menu action mapper. A directed
// table covers key and axis extremes, triggers and attach. Random traffic
// then runs under several repeat and threshold settings and several idle
// and stall patterns. A held direction under the largest delay and interval
// checks that no repeat comes early. Actions are checked against an in-bench
// predictor or, for typed table rows, against the row's own action.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_pad_event_to_action_repeat;
  import pear_pkg::*;

  localparam int         CYCLE_LIMIT   = 400000;
  localparam int         SETTLE_CYCLES = 6;
  localparam logic [2:0] NO_DIR        = 3'd4;
  localparam logic [15:0] TIMER_MAX    = 16'hFFFF;

  typedef struct packed {
    opcode_t            op;
    logic [1:0]         slot;
    logic [9:0]         code;
    logic signed [31:0] value;
    logic [30:0]        second;
  } pad_item_t;

  typedef enum {FROM_MODEL, TYPED_NONE, TYPED_ACT} row_check_t;

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_ready;
  logic [1:0]          opcode;
  logic [1:0]          slot;
  logic [9:0]          event_code;
  logic signed [31:0]  event_value;
  logic [30:0]         second_level;
  logic                out_valid;
  logic                out_ready;
  logic [3:0]          action;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  pad_event_to_action_repeat dut (.*);

  // predictor state and register copies
  logic [15:0] cfg_delay;
  logic [15:0] cfg_interval;
  logic [30:0] cfg_thr;
  logic [2:0]  held_dir;
  logic [15:0] held_ms;
  logic [15:0] since_repeat_ms;
  int          axis_pos [4][4];
  bit          trig_on [4][2];
  logic [30:0] left_lvl [4];
  logic [30:0] right_lvl [4];

  logic [3:0]  pending_actions [$];
  logic [3:0]  want_action;

  pad_item_t   row_items [$];
  row_check_t  row_checks [$];
  logic [3:0]  row_acts [$];

  int unsigned dir_keys [0:7] = '{103, 544, 108, 545, 105, 546, 106, 547};
  int unsigned button_keys [0:21] = '{304, 315, 28, 96, 57, 305, 1, 14, 308, 33, 307,
                                      47, 310, 104, 311, 109, 15, 312, 51, 313, 52, 16};
  int unsigned axis_codes [0:5] = '{16, 17, 0, 1, 2, 5};

  int gap_pct;
  int stall_pct;
  int failures;
  int items_sent;
  int actions_checked;
  int reads_checked;
  int settings_used;
  int cycle_count;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_actions.size() == 0) begin
        $error("action: expected none, got %0d", action);
        failures++;
      end else begin
        want_action = pending_actions.pop_front();
        if (action !== want_action) begin
          $error("action: expected %0d, got %0d", want_action, action);
          failures++;
        end
      end
      actions_checked++;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("pad_event_to_action_repeat regression: fail");
      $finish;
    end
  end

  function automatic void hold_direction(input logic [1:0] d);
    held_dir        = {1'b0, d};
    held_ms         = '0;
    since_repeat_ms = '0;
  endfunction

  function automatic bit predict_action(input pad_item_t it, output logic [3:0] act);
    longint      v;
    longint      lim;
    int          dir;
    int          code_act;
    int          ax;
    int          tg;
    int          nxt;
    logic [1:0]  neg_d;
    logic [1:0]  pos_d;
    logic [1:0]  d;
    logic [30:0] lvl;
    bit          pulled;
    v = $signed(it.value);
    act = '0;
    dir = -1;
    code_act = -1;
    ax = -1;
    tg = -1;
    lim = 1;
    neg_d = DIR_LEFT;
    pos_d = DIR_RIGHT;
    case (it.op)
      OP_KEY: begin
        case (it.code)
          10'd103, 10'd544: dir = int'(DIR_UP);
          10'd108, 10'd545: dir = int'(DIR_DOWN);
          10'd105, 10'd546: dir = int'(DIR_LEFT);
          10'd106, 10'd547: dir = int'(DIR_RIGHT);
          default: ;
        endcase
        if (dir >= 0) begin
          if (v != 0) begin
            hold_direction(dir[1:0]);
            act = dir[3:0];
            return 1'b1;
          end
          // drop the held direction only if this key is the one held
          if (held_dir == dir[2:0]) held_dir = NO_DIR;
          return 1'b0;
        end
        if (v == 0) return 1'b0;
        case (it.code)
          10'd304, 10'd315, 10'd28, 10'd96, 10'd57: code_act = int'(ACT_CONFIRM);
          10'd305, 10'd1, 10'd14:                    code_act = int'(ACT_BACK);
          10'd308, 10'd33:                           code_act = int'(ACT_FAVORITE);
          10'd307, 10'd47:                           code_act = int'(ACT_VIEW);
          10'd310, 10'd104:                          code_act = int'(ACT_TABPREV);
          10'd311, 10'd109, 10'd15:                  code_act = int'(ACT_TABNEXT);
          10'd312, 10'd51:                           code_act = int'(ACT_JUMPPREV);
          10'd313, 10'd52:                           code_act = int'(ACT_JUMPNEXT);
          10'd16:                                    code_act = int'(ACT_QUIT);
          default: ;
        endcase
        if (code_act < 0) return 1'b0;
        act = code_act[3:0];
        return 1'b1;
      end
      OP_TICK: begin
        if (held_dir == NO_DIR) return 1'b0;
        if (held_ms != TIMER_MAX) held_ms++;
        if (since_repeat_ms != TIMER_MAX) since_repeat_ms++;
        if (held_ms < cfg_delay || since_repeat_ms < cfg_interval) return 1'b0;
        since_repeat_ms = '0;
        act = {1'b0, held_dir};
        return 1'b1;
      end
      OP_ATTACH: begin
        left_lvl[it.slot]  = (v < 0) ? '0 : it.value[30:0];
        right_lvl[it.slot] = it.second;
        for (int a = 0; a < 4; a++) axis_pos[it.slot][a] = 0;
        trig_on[it.slot][0] = 1'b0;
        trig_on[it.slot][1] = 1'b0;
        return 1'b0;
      end
      default: begin
        case (it.code)
          10'd16: ax = 0;
          10'd17: begin
            ax = 1;
            neg_d = DIR_UP;
            pos_d = DIR_DOWN;
          end
          10'd0: begin
            ax = 2;
            lim = longint'(cfg_thr);
          end
          10'd1: begin
            ax = 3;
            lim = longint'(cfg_thr);
            neg_d = DIR_UP;
            pos_d = DIR_DOWN;
          end
          10'd2: tg = 0;
          10'd5: tg = 1;
          default: return 1'b0;
        endcase
        if (tg >= 0) begin
          lvl = (tg == 0) ? left_lvl[it.slot] : right_lvl[it.slot];
          if (lvl == '0) return 1'b0;
          pulled = (v >= longint'({1'b0, lvl}));
          if (pulled == trig_on[it.slot][tg]) return 1'b0;
          trig_on[it.slot][tg] = pulled;
          if (!pulled) return 1'b0;
          act = (tg == 0) ? ACT_JUMPPREV : ACT_JUMPNEXT;
          return 1'b1;
        end
        nxt = (v <= -lim) ? -1 : ((v >= lim) ? 1 : 0);
        if (nxt == axis_pos[it.slot][ax]) return 1'b0;
        if (axis_pos[it.slot][ax] == -1 && held_dir == {1'b0, neg_d}) held_dir = NO_DIR;
        if (axis_pos[it.slot][ax] == 1 && held_dir == {1'b0, pos_d}) held_dir = NO_DIR;
        axis_pos[it.slot][ax] = nxt;
        if (nxt == 0) return 1'b0;
        d = (nxt < 0) ? neg_d : pos_d;
        hold_direction(d);
        act = {2'b00, d};
        return 1'b1;
      end
    endcase
  endfunction

  function automatic pad_item_t random_item();
    pad_item_t it;
    longint    near;
    int        pick;
    it.op     = OP_TICK;
    it.slot   = 2'($urandom_range(0, 3));
    it.code   = 10'($urandom);
    it.value  = $urandom;
    it.second = 31'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      it.op = OP_KEY;
      pick = $urandom_range(0, 9);
      if (pick < 5) it.code = 10'(dir_keys[$urandom_range(0, 7)]);
      else if (pick < 9) it.code = 10'(button_keys[$urandom_range(0, 21)]);
      pick = $urandom_range(0, 19);
      if (pick < 11) it.value = 1;
      else if (pick < 17) it.value = 0;
    end else if (pick < 55) begin
      it.op = OP_AXIS;
      if ($urandom_range(0, 9) != 0) it.code = 10'(axis_codes[$urandom_range(0, 5)]);
      // aim values at the edge of the active threshold or trigger level
      near = (it.code == 10'd2) ? longint'(left_lvl[it.slot]) :
             (it.code == 10'd5) ? longint'(right_lvl[it.slot]) : longint'(cfg_thr);
      if (it.code == 10'd16 || it.code == 10'd17) near = 1;
      case ($urandom_range(0, 5))
        0: it.value = 32'(near);
        1: it.value = 32'(near - 1);
        2: it.value = 32'(-near);
        3: it.value = 32'(1 - near);
        4: it.value = 0;
        default: ;
      endcase
    end else if (pick >= 90) begin
      it.op = OP_ATTACH;
      pick = $urandom_range(0, 9);
      if (pick < 6) it.value = $urandom_range(0, 3000);
      else if (pick == 6) it.value = 0;
      else if (pick == 7) it.value = -$signed($urandom_range(1, 3000));
      pick = $urandom_range(0, 9);
      if (pick < 6) it.second = 31'($urandom_range(0, 3000));
      else if (pick < 8) it.second = '0;
    end
    return it;
  endfunction

  task automatic add_row(input opcode_t op, input logic [1:0] s, input logic [9:0] code,
                         input logic signed [31:0] value, input logic [30:0] second,
                         input row_check_t chk, input logic [3:0] act);
    pad_item_t it;
    it.op     = op;
    it.slot   = s;
    it.code   = code;
    it.value  = value;
    it.second = second;
    row_items  = {row_items, it};
    row_checks = {row_checks, chk};
    row_acts   = {row_acts, act};
  endtask

  task automatic send_item(input pad_item_t it, input row_check_t chk,
                           input logic [3:0] typed_act);
    logic [3:0] act;
    bit         fires;
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    opcode       <= it.op;
    slot         <= it.slot;
    event_code   <= it.code;
    event_value  <= it.value;
    second_level <= it.second;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    fires = predict_action(it, act);
    if (chk == FROM_MODEL) begin
      if (fires) pending_actions = {pending_actions, act};
    end else if (chk == TYPED_ACT) begin
      pending_actions = {pending_actions, typed_act};
    end
    items_sent++;
  endtask

  // hold the sender until every expected action has come out
  task automatic drain_actions();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_actions.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic read_reg(input logic [1:0] idx, input logic [31:0] want);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== want) begin
      $error("prdata[reg %0d]: expected 0x%h, got 0x%h", idx, want, prdata);
      failures++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    reads_checked++;
  endtask

  task automatic configure(input logic [15:0] delay, input logic [15:0] interval,
                           input logic [30:0] thr);
    drain_actions();
    // let items that give no action clear the pipeline
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(REG_DELAY, {16'd0, delay});
    write_reg(REG_INTERVAL, {16'd0, interval});
    write_reg(REG_THRESHOLD, {1'b0, thr});
    cfg_delay    = delay;
    cfg_interval = interval;
    cfg_thr      = thr;
    read_reg(REG_DELAY, {16'd0, delay});
    read_reg(REG_INTERVAL, {16'd0, interval});
    read_reg(REG_THRESHOLD, {1'b0, thr});
    settings_used++;
  endtask

  task automatic run_random(input int count, input int gap, input int stall);
    gap_pct   = gap;
    stall_pct = stall;
    for (int n = 0; n < count; n++) begin
      if (n == count / 2 || $urandom_range(0, 249) == 0) drain_actions();
      send_item(random_item(), FROM_MODEL, 4'd0);
    end
  endtask

  initial begin
    pad_item_t it;
    rst          = 1'b1;
    in_valid     = 1'b0;
    opcode       = OP_KEY;
    slot         = '0;
    event_code   = '0;
    event_value  = '0;
    second_level = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    gap_pct      = 0;
    stall_pct    = 0;
    failures     = 0;
    items_sent   = 0;
    actions_checked = 0;
    reads_checked   = 0;
    settings_used   = 1;
    cycle_count     = 0;
    cfg_delay    = DELAY_RESET;
    cfg_interval = INTERVAL_RESET;
    cfg_thr      = THRESHOLD_RESET;
    held_dir     = NO_DIR;
    held_ms      = '0;
    since_repeat_ms = '0;
    for (int s = 0; s < 4; s++) begin
      for (int a = 0; a < 4; a++) axis_pos[s][a] = 0;
      trig_on[s][0] = 1'b0;
      trig_on[s][1] = 1'b0;
      left_lvl[s]   = '0;
      right_lvl[s]  = '0;
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    read_reg(REG_DELAY, {16'd0, DELAY_RESET});
    read_reg(REG_INTERVAL, {16'd0, INTERVAL_RESET});
    read_reg(REG_THRESHOLD, {1'b0, THRESHOLD_RESET});

    add_row(OP_KEY,    2'd0, 10'd16,   1,             '0, TYPED_ACT,  ACT_QUIT);
    add_row(OP_KEY,    2'd3, 10'd304,  0,             '0, TYPED_NONE, 4'd0);
    add_row(OP_KEY,    2'd0, 10'd1023, -1,            '0, TYPED_NONE, 4'd0);
    add_row(OP_KEY,    2'd2, 10'd103,  1,             '0, TYPED_ACT,  {2'b00, DIR_UP});
    add_row(OP_TICK,   2'd0, 10'd0,    0,             '0, FROM_MODEL, 4'd0);
    add_row(OP_KEY,    2'd0, 10'd103,  0,             '0, TYPED_NONE, 4'd0);
    add_row(OP_TICK,   2'd1, 10'd0,    0,             '0, TYPED_NONE, 4'd0);
    add_row(OP_AXIS,   2'd0, 10'd16,   32'sh80000000, '0, TYPED_ACT,  {2'b00, DIR_LEFT});
    add_row(OP_AXIS,   2'd0, 10'd16,   0,             '0, TYPED_NONE, 4'd0);
    add_row(OP_AXIS,   2'd3, 10'd17,   32'sh7FFFFFFF, '0, TYPED_ACT,  {2'b00, DIR_DOWN});
    add_row(OP_AXIS,   2'd1, 10'd0,    16000,         '0, TYPED_ACT,  {2'b00, DIR_RIGHT});
    add_row(OP_AXIS,   2'd1, 10'd1,    -16000,        '0, TYPED_ACT,  {2'b00, DIR_UP});
    add_row(OP_AXIS,   2'd2, 10'd1,    15999,         '0, TYPED_NONE, 4'd0);
    add_row(OP_AXIS,   2'd1, 10'd0,    -16000,        '0, FROM_MODEL, 4'd0);
    add_row(OP_ATTACH, 2'd2, 10'd0,    -5,   31'h7FFFFFFF, TYPED_NONE, 4'd0);
    add_row(OP_AXIS,   2'd2, 10'd2,    32'sh7FFFFFFF, '0, TYPED_NONE, 4'd0);
    add_row(OP_AXIS,   2'd2, 10'd5,    32'sh7FFFFFFF, '0, TYPED_ACT,  ACT_JUMPNEXT);
    add_row(OP_AXIS,   2'd2, 10'd5,    0,             '0, TYPED_NONE, 4'd0);
    add_row(OP_ATTACH, 2'd0, 10'd1023, 100,           '0, TYPED_NONE, 4'd0);
    add_row(OP_AXIS,   2'd0, 10'd2,    100,           '0, TYPED_ACT,  ACT_JUMPPREV);
    add_row(OP_AXIS,   2'd0, 10'd2,    200,           '0, TYPED_NONE, 4'd0);
    add_row(OP_AXIS,   2'd0, 10'd5,    500,           '0, TYPED_NONE, 4'd0);
    add_row(OP_AXIS,   2'd1, 10'd3,    1,             '0, TYPED_NONE, 4'd0);
    add_row(OP_KEY,    2'd1, 10'd545,  32'sh80000000, '0, TYPED_ACT,  {2'b00, DIR_DOWN});
    add_row(OP_AXIS,   2'd0, 10'd2,    99,            '0, FROM_MODEL, 4'd0);

    for (int r = 0; r < row_items.size(); r++) begin
      send_item(row_items[r], row_checks[r], row_acts[r]);
    end

    configure(16'd3, 16'd2, 31'd16000);
    run_random(282, 0, 0);
    configure(16'd0, 16'd0, 31'd1);
    run_random(282, 63, 0);
    configure(16'd10, 16'd4, 31'h7FFFFFFF);
    run_random(282, 0, 63);
    // a zero threshold reads a centred stick as pushed negative
    configure(16'd5, 16'd1, 31'd0);
    run_random(282, 29, 29);

    // hold one direction under the largest delay; no repeat may come
    configure(16'hFFFF, 16'hFFFF, 31'd16000);
    gap_pct   = 0;
    stall_pct = 0;
    it        = '0;
    it.op     = OP_KEY;
    it.code   = 10'd106;
    it.value  = 1;
    send_item(it, FROM_MODEL, 4'd0);
    it.op     = OP_TICK;
    for (int n = 0; n < 20; n++) send_item(it, FROM_MODEL, 4'd0);

    in_valid <= 1'b0;
    while (pending_actions.size() != 0) @(posedge clk);
    repeat (2 * SETTLE_CYCLES) @(posedge clk);

    $display("Ran %0d input items across %0d register settings with mixed idle and stall.",
             items_sent, settings_used);
    $display("Compared %0d actions and %0d register reads.", actions_checked, reads_checked);
    if (failures == 0) begin
      $display("pad_event_to_action_repeat regression: pass");
    end else begin
      $display("pad_event_to_action_repeat regression: fail");
    end
    $finish;
  end

endmodule
